// ----- rtl/core/prl_pkg.sv -----
// Shared types and constants for the ping-pong line receiver.
// Used by the top level, the port checker and the testbench.
`default_nettype none

package prl_pkg;

  // default size of one line buffer, in bytes
  localparam int unsigned LINE_BUFFER_BYTES_DEF = 64;

  // fixed field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned STATUS_W = 3;

  // line terminators
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // request actions
  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_TAKE    = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED    = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_ENDED     = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_STOPPED   = 3'd4,
    STAT_CHAR      = 3'd5,
    STAT_NOLINE    = 3'd6
  } status_e;

  // control states
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_STREAM = 1'b1
  } state_e;

  // one request
  typedef struct packed {
    logic               action;
    logic [BYTE_W-1:0]  byte_value;
    logic [LIMIT_W-1:0] take_limit;
  } req_t;

  // one result
  typedef struct packed {
    status_e            status;
    logic [BYTE_W-1:0]  char_out;
    logic [LEN_W-1:0]   line_length;
    logic               last;
    logic [1:0]         lines_ready;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/ping_pong_line_receiver.sv -----
// Receive item: one result in the next cycle; a new request may follow at once.
// Take item: first character in the next cycle, then one character per
// cycle from the single read port of the line store; busy while the remaining characters stream out.
// Takes that find no line, or copy nothing, give a single result in the next cycle.
// Reset clears fill counts, ready mask and pointers; the line store is not cleared.
// Results are shown for one cycle on res_valid_o; the receiver cannot stall.
`default_nettype none

module ping_pong_line_receiver #(
  parameter int unsigned LINE_BUFFER_BYTES = prl_pkg::LINE_BUFFER_BYTES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire prl_pkg::req_t req_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output prl_pkg::res_t      res_o
);

  localparam int unsigned FILL_W = $clog2(LINE_BUFFER_BYTES);
  localparam int unsigned DEPTH  = 2 * LINE_BUFFER_BYTES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_BUFFER_BYTES - 1);

  // store address of position pos in buffer b
  function automatic logic [ADDR_W-1:0] store_addr(input logic b,
                                                   input logic [FILL_W-1:0] pos);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(pos);
    if (b) begin
      a = a + ADDR_W'(LINE_BUFFER_BYTES);
    end
    return a;
  endfunction

  // control state
  prl_pkg::state_e        state_q, state_d;
  logic [1:0][FILL_W-1:0] fill_q, fill_d;
  logic                   active_q, active_d;
  logic [1:0]             ready_q, ready_d;
  logic                   rptr_q, rptr_d;
  logic                   stopped_q, stopped_d;
  logic                   buf_q, buf_d;
  logic [FILL_W-1:0]      pos_q, pos_d;
  logic [FILL_W-1:0]      copy_q, copy_d;

  // result registers
  logic                          res_valid_q, res_valid_d;
  prl_pkg::status_e              res_status_q, res_status_d;
  logic [prl_pkg::LEN_W-1:0]     res_len_q, res_len_d;
  logic                          res_last_q, res_last_d;
  logic                          res_mem_q, res_mem_d;

  // line store port signals
  logic                          mem_we, mem_re;
  logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
  logic [prl_pkg::BYTE_W-1:0]    mem_rdata;

  // take helpers
  logic                          take_sel;
  logic [FILL_W-1:0]             take_fill, take_copy;
  logic [prl_pkg::LIMIT_W-1:0]   limit_m1;
  logic [FILL_W-1:0]             fill_act;

  prl_line_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (prl_pkg::BYTE_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req_i.byte_value),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // take line choice and copy length
  always_comb begin
    take_sel  = ready_q[rptr_q] ? rptr_q : ~rptr_q;
    take_fill = fill_q[take_sel];
    limit_m1  = req_i.take_limit - prl_pkg::LIMIT_W'(1);
    if (prl_pkg::LIMIT_W'(take_fill) < req_i.take_limit) begin
      take_copy = take_fill;
    end else begin
      take_copy = limit_m1[FILL_W-1:0];
    end
    fill_act = fill_q[active_q];
  end

  // next state and outputs
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    active_d     = active_q;
    ready_d      = ready_q;
    rptr_d       = rptr_q;
    stopped_d    = stopped_q;
    buf_d        = buf_q;
    pos_d        = pos_q;
    copy_d       = copy_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_len_d    = res_len_q;
    res_last_d   = res_last_q;
    res_mem_d    = res_mem_q;
    mem_we       = 1'b0;
    mem_waddr    = store_addr(active_q, fill_act);
    mem_re       = 1'b0;
    mem_raddr    = store_addr(buf_q, pos_q);

    case (state_q)
      prl_pkg::S_IDLE: begin
        if (start_i) begin
          res_valid_d = 1'b1;
          res_last_d  = 1'b1;
          res_len_d   = '0;
          res_mem_d   = 1'b0;
          if (req_i.action == prl_pkg::ACT_RECEIVE) begin
            // receive a byte
            if (stopped_q) begin
              res_status_d = prl_pkg::STAT_STOPPED;
            end else if (req_i.byte_value == prl_pkg::CHAR_CR ||
                         req_i.byte_value == prl_pkg::CHAR_LF) begin
              if (fill_act != '0) begin
                ready_d[active_q] = 1'b1;
                if (!ready_q[~active_q]) begin
                  active_d           = ~active_q;
                  fill_d[~active_q]  = '0;
                end else begin
                  stopped_d = 1'b1;
                end
                res_status_d = prl_pkg::STAT_ENDED;
              end else begin
                res_status_d = prl_pkg::STAT_EMPTY;
              end
            end else if (fill_act < FILL_MAX) begin
              mem_we           = 1'b1;
              fill_d[active_q] = fill_act + FILL_W'(1);
              res_status_d     = prl_pkg::STAT_STORED;
            end else begin
              res_status_d = prl_pkg::STAT_FULL;
            end
          end else begin
            // take one line
            if (req_i.take_limit == '0 || ready_q == 2'b00) begin
              res_status_d = prl_pkg::STAT_NOLINE;
            end else begin
              fill_d[take_sel]  = '0;
              ready_d[take_sel] = 1'b0;
              rptr_d            = ~take_sel;
              if (stopped_q) begin
                active_d  = take_sel;
                stopped_d = 1'b0;
              end
              res_status_d = prl_pkg::STAT_CHAR;
              res_len_d    = prl_pkg::LEN_W'(take_copy);
              if (take_copy != '0) begin
                mem_re     = 1'b1;
                mem_raddr  = store_addr(take_sel, '0);
                res_mem_d  = 1'b1;
                res_last_d = (take_copy == FILL_W'(1));
                buf_d      = take_sel;
                copy_d     = take_copy;
                pos_d      = FILL_W'(1);
                if (take_copy != FILL_W'(1)) begin
                  state_d = prl_pkg::S_STREAM;
                end
              end
            end
          end
        end
      end
      prl_pkg::S_STREAM: begin
        // one character read per cycle
        mem_re      = 1'b1;
        res_valid_d = 1'b1;
        res_mem_d   = 1'b1;
        res_last_d  = (pos_q == copy_q - FILL_W'(1));
        pos_d       = pos_q + FILL_W'(1);
        if (res_last_d) begin
          state_d = prl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = prl_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= prl_pkg::S_IDLE;
      fill_q       <= '0;
      active_q     <= 1'b0;
      ready_q      <= 2'b00;
      rptr_q       <= 1'b0;
      stopped_q    <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      active_q     <= active_d;
      ready_q      <= ready_d;
      rptr_q       <= rptr_d;
      stopped_q    <= stopped_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    buf_q        <= buf_d;
    pos_q        <= pos_d;
    copy_q       <= copy_d;
    res_status_q <= res_status_d;
    res_len_q    <= res_len_d;
    res_last_q   <= res_last_d;
    res_mem_q    <= res_mem_d;
  end

  // result port
  assign busy_o      = (state_q == prl_pkg::S_STREAM);
  assign res_valid_o = res_valid_q;
  always_comb begin
    res_o.status      = res_status_q;
    res_o.char_out    = res_mem_q ? mem_rdata : '0;
    res_o.line_length = res_len_q;
    res_o.last        = res_last_q;
    res_o.lines_ready = ready_q;
  end

endmodule

`default_nettype wire

// ----- rtl/core/prl_line_mem.sv -----
// Line store for both ping-pong buffers: one write port, one read port,
// read data registered. Depends on nothing but its parameters.
`default_nettype none

module prl_line_mem #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/prl_checker.sv -----
// Port-level checks for the ping-pong line receiver, bound to the top level.
// Depends on prl_pkg for the request and result types.
`default_nettype none

module prl_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire prl_pkg::req_t req_i,
  input wire logic          busy_o,
  input wire logic          res_valid_o,
  input wire prl_pkg::res_t res_o
);

  // every accepted request answers in the next cycle
  a_req_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> res_valid_o)
    else $error("accepted request without result");

  // a receive gives exactly one result
  a_receive_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.action == prl_pkg::ACT_RECEIVE) |=>
    (res_o.last && res_o.line_length == '0))
    else $error("receive result not single");

  // a line still streaming keeps the block busy
  a_stream_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy_o)
    else $error("unfinished line while not busy");

  // busy only while a line streams out
  a_busy_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (res_valid_o && res_o.status == prl_pkg::STAT_CHAR))
    else $error("busy without line character");

  // line characters do not change the ready mask mid-line
  a_mask_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> $stable(res_o.lines_ready))
    else $error("ready mask changed inside a line");

endmodule

bind ping_pong_line_receiver prl_checker u_prl_checker (.*);

`default_nettype wire

// ----- dv/ping_pong_line_receiver_tb.sv -----
// Self-checking testbench for the ping-pong line receiver.
// Runs directed and random requests; checks each result against a fixed row or the predictor.
// Depends on prl_pkg and the ping_pong_line_receiver top level.

module ping_pong_line_receiver_tb;
  import prl_pkg::*;

  localparam int unsigned LINE_BYTES    = LINE_BUFFER_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS  = 330;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PLAN_ROWS     = 18;

  // one directed row; a fixed row carries its single expected result
  typedef struct {
    req_t req;
    bit   fixed;
    res_t res;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  // expectation for the request on the port when it is a fixed row
  bit   fixed_valid;
  res_t fixed_res;

  // predictor state
  bit [7:0]    line_mem [2*LINE_BYTES];
  int unsigned buf_fill [2];
  bit          rx_buf;
  bit          take_ptr;
  bit [1:0]    ready_bits;
  bit          rx_halted;

  res_t step_results [$];
  res_t awaited [$];

  int unsigned idle_pct;
  int unsigned cycle_count = 0;
  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_lines_ended = 0;
  int unsigned n_lines_taken = 0;
  int unsigned n_chars = 0;
  int unsigned n_full_drops = 0;
  int unsigned n_halted_drops = 0;
  int unsigned n_empty = 0;
  int unsigned n_no_line = 0;

  ping_pong_line_receiver DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // cycle counter and run limit
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic void add_result(status_e st, logic [7:0] ch, logic [5:0] len, logic last);
    res_t x;
    x.status      = st;
    x.char_out    = ch;
    x.line_length = len;
    x.last        = last;
    x.lines_ready = ready_bits;
    step_results.push_back(x);
  endfunction

  // results of one accepted request, state updated as the block does
  task automatic predict_request(input req_t r);
    bit          a;
    bit          idx;
    int unsigned lim;
    int unsigned fl;
    int unsigned cp;
    status_e     st;
    step_results.delete();
    n_items++;
    if (r.action == ACT_RECEIVE) begin
      a = rx_buf;
      if (rx_halted) begin
        st = STAT_STOPPED;
        n_halted_drops++;
      end else if (r.byte_value == CHAR_CR || r.byte_value == CHAR_LF) begin
        if (buf_fill[a] > 0) begin
          ready_bits[a] = 1'b1;
          // switch buffers, or halt when the other one still holds a line
          if (!ready_bits[!a]) begin
            rx_buf = !a;
            buf_fill[!a] = 0;
          end else begin
            rx_halted = 1'b1;
          end
          st = STAT_ENDED;
          n_lines_ended++;
        end else begin
          st = STAT_EMPTY;
          n_empty++;
        end
      end else if (buf_fill[a] < LINE_BYTES - 1) begin
        line_mem[a * LINE_BYTES + buf_fill[a]] = r.byte_value;
        buf_fill[a]++;
        st = STAT_STORED;
      end else begin
        st = STAT_FULL;
        n_full_drops++;
      end
      add_result(st, 8'h00, 6'd0, 1'b1);
    end else begin
      lim = r.take_limit;
      if (lim == 0 || ready_bits == 2'b00) begin
        n_no_line++;
        add_result(STAT_NOLINE, 8'h00, 6'd0, 1'b1);
      end else begin
        idx = take_ptr;
        if (!ready_bits[idx]) idx = !idx;
        fl = buf_fill[idx];
        // truncate to limit minus one when the line does not fit
        cp = (fl < lim) ? fl : lim - 1;
        if (cp > LINE_BYTES - 1) cp = LINE_BYTES - 1;
        buf_fill[idx] = 0;
        ready_bits[idx] = 1'b0;
        take_ptr = !idx;
        if (rx_halted) begin
          rx_buf = idx;
          rx_halted = 1'b0;
        end
        n_lines_taken++;
        n_chars += cp;
        if (cp == 0) begin
          add_result(STAT_CHAR, 8'h00, 6'd0, 1'b1);
        end else begin
          for (int i = 0; i < cp; i++)
            add_result(STAT_CHAR, line_mem[idx * LINE_BYTES + i], 6'(cp), (i + 1 == cp));
        end
      end
    end
  endtask

  // result check and request capture, both at the rising edge
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      n_results++;
      if (awaited.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected: %h", n_results, res_o));
      end else begin
        want = awaited.pop_front();
        if (res_o.status !== want.status)
          flag_error($sformatf("result %0d status got %0d want %0d",
                               n_results, res_o.status, want.status));
        if (res_o.char_out !== want.char_out)
          flag_error($sformatf("result %0d char_out got %h want %h",
                               n_results, res_o.char_out, want.char_out));
        if (res_o.line_length !== want.line_length)
          flag_error($sformatf("result %0d line_length got %0d want %0d",
                               n_results, res_o.line_length, want.line_length));
        if (res_o.last !== want.last)
          flag_error($sformatf("result %0d last got %b want %b",
                               n_results, res_o.last, want.last));
        if (res_o.lines_ready !== want.lines_ready)
          flag_error($sformatf("result %0d lines_ready got %b want %b",
                               n_results, res_o.lines_ready, want.lines_ready));
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      predict_request(req_i);
      if (fixed_valid) awaited.push_back(fixed_res);
      else foreach (step_results[i]) awaited.push_back(step_results[i]);
    end
  end

  // drive one request at the falling edge, with a random gap first
  task automatic send_req(input logic act, input logic [7:0] b, input logic [6:0] lim,
                          input bit fixed, input res_t fres);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i.action <= act;
    req_i.byte_value <= b;
    req_i.take_limit <= lim;
    fixed_valid <= fixed;
    fixed_res <= fres;
    do @(posedge clk_i); while (busy_o);
  endtask

  // hold off until every expected result has come
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [6:0] random_limit();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      default: return 7'($urandom_range(2, 64));
    endcase
  endfunction

  // stimulus
  initial begin
    plan_row_t   plan [PLAN_ROWS];
    int unsigned target;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  b;

    start_i = 1'b0;
    req_i = '0;
    fixed_valid = 1'b0;
    fixed_res = '0;
    rst_ni = 1'b0;
    idle_pct = 30;

    // directed: empty lines, extremes, truncation, halt, limit one, empty takes
    plan = '{
      '{'{ACT_TAKE,    8'h5A,   7'd5},  1'b1, '{STAT_NOLINE,  8'h00, 6'd0, 1'b1, 2'b00}},
      '{'{ACT_RECEIVE, CHAR_CR, 7'd64}, 1'b1, '{STAT_EMPTY,   8'h00, 6'd0, 1'b1, 2'b00}},
      '{'{ACT_RECEIVE, CHAR_LF, 7'd0},  1'b1, '{STAT_EMPTY,   8'h00, 6'd0, 1'b1, 2'b00}},
      '{'{ACT_RECEIVE, 8'h00,   7'd63}, 1'b1, '{STAT_STORED,  8'h00, 6'd0, 1'b1, 2'b00}},
      '{'{ACT_RECEIVE, 8'hFF,   7'd1},  1'b1, '{STAT_STORED,  8'h00, 6'd0, 1'b1, 2'b00}},
      '{'{ACT_RECEIVE, 8'h41,   7'd2},  1'b1, '{STAT_STORED,  8'h00, 6'd0, 1'b1, 2'b00}},
      '{'{ACT_RECEIVE, CHAR_LF, 7'd0},  1'b1, '{STAT_ENDED,   8'h00, 6'd0, 1'b1, 2'b01}},
      '{'{ACT_TAKE,    8'hFF,   7'd0},  1'b1, '{STAT_NOLINE,  8'h00, 6'd0, 1'b1, 2'b01}},
      '{'{ACT_TAKE,    8'h00,   7'd3},  1'b0, '0},
      '{'{ACT_RECEIVE, 8'h78,   7'd0},  1'b1, '{STAT_STORED,  8'h00, 6'd0, 1'b1, 2'b00}},
      '{'{ACT_RECEIVE, CHAR_CR, 7'd0},  1'b1, '{STAT_ENDED,   8'h00, 6'd0, 1'b1, 2'b10}},
      '{'{ACT_RECEIVE, 8'h79,   7'd0},  1'b1, '{STAT_STORED,  8'h00, 6'd0, 1'b1, 2'b10}},
      '{'{ACT_RECEIVE, CHAR_LF, 7'd0},  1'b1, '{STAT_ENDED,   8'h00, 6'd0, 1'b1, 2'b11}},
      '{'{ACT_RECEIVE, 8'h7A,   7'd0},  1'b1, '{STAT_STOPPED, 8'h00, 6'd0, 1'b1, 2'b11}},
      '{'{ACT_RECEIVE, CHAR_CR, 7'd0},  1'b1, '{STAT_STOPPED, 8'h00, 6'd0, 1'b1, 2'b11}},
      '{'{ACT_TAKE,    8'h33,   7'd1},  1'b1, '{STAT_CHAR,    8'h00, 6'd0, 1'b1, 2'b01}},
      '{'{ACT_TAKE,    8'h00,   7'd64}, 1'b0, '0},
      '{'{ACT_TAKE,    8'hC3,   7'd64}, 1'b1, '{STAT_NOLINE,  8'h00, 6'd0, 1'b1, 2'b00}}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i])
      send_req(plan[i].req.action, plan[i].req.byte_value, plan[i].req.take_limit,
               plan[i].fixed, plan[i].res);
    wait_drained();

    // random: three idle settings, a full drain before each
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 30 : (phase == 1) ? 74 : 0;
      if (phase != 0) wait_drained();
      target = n_items + RANDOM_ITEMS / 3;
      while (n_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // well-formed line, now and then long enough to fill the buffer
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 12);
          repeat (len) begin
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
            send_req(ACT_RECEIVE, b, random_limit(), 1'b0, '0);
          end
          send_req(ACT_RECEIVE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF, random_limit(),
                   1'b0, '0);
          if ($urandom_range(0, 3) == 0)
            send_req(ACT_RECEIVE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF, random_limit(),
                     1'b0, '0);
          if ($urandom_range(0, 99) < 60)
            send_req(ACT_TAKE, 8'($urandom_range(0, 255)), random_limit(), 1'b0, '0);
        end else if (pick < 85) begin
          send_req(ACT_TAKE, 8'($urandom_range(0, 255)), random_limit(), 1'b0, '0);
        end else begin
          send_req(ACT_RECEIVE, 8'($urandom_range(0, 255)), random_limit(), 1'b0, '0);
        end
      end
    end
    wait_drained();

    $display("Covered %0d requests and %0d results: %0d lines ended, %0d taken, %0d chars out",
             n_items, n_results, n_lines_ended, n_lines_taken, n_chars);
    $display("Drops: %0d full, %0d while halted; %0d empty lines; %0d takes with no line",
             n_full_drops, n_halted_drops, n_empty, n_no_line);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
